FILE: hw/rtl/shmm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shmm_pkg
// Shared types, constants and the per-byte fold function of the string hash
// ----------------------------------------------------------------------------
package shmm_pkg;

    localparam int MAX_CHARS_DEFAULT = 32;

    localparam int CFG_INDEX_W = 3;

    localparam logic [31:0] INIT_VALUE_RESET = 32'd5381;
    localparam logic [31:0] HASH_MASK_RESET  = 32'hFFFF_FFFF;
    localparam logic [7:0]  END_CHAR_RESET   = 8'd0;

    typedef enum logic [1:0] {
        MODE_DJB2  = 2'd0,
        MODE_DJB2A = 2'd1,
        MODE_SDBM  = 2'd2
    } hash_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HASH_MODE   = 3'd0,
        REG_HASH_MASK   = 3'd1,
        REG_INIT_VALUE  = 3'd2,
        REG_END_CHAR    = 3'd3,
        REG_ZERO_FIX_EN = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]  hash_mode;
        logic [31:0] hash_mask;
        logic [31:0] init_value;
        logic [7:0]  end_char;
        logic        zero_fix_enable;
    } cfg_t;

    function automatic logic [31:0] fold(input logic [1:0] mode,
                                         input logic [31:0] h,
                                         input logic [7:0] b);
        logic [31:0] h33;
        logic [31:0] res;
        h33 = (h << 5) + h;
        case (mode)
            MODE_DJB2:  res = h33 + {24'd0, b};
            MODE_DJB2A: res = h33 ^ {24'd0, b};
            default:    res = {24'd0, b} + (h << 6) + (h << 16) - h;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/shmm_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shmm_cfg_regs
// Configuration register file written through the index/data channel
// ----------------------------------------------------------------------------
module shmm_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic [shmm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [31:0]                       cfg_data,
    output shmm_pkg::cfg_t                         cfg
);

    shmm_pkg::cfg_t cfg_reg;
    shmm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                shmm_pkg::REG_HASH_MODE:   cfg_next.hash_mode       = cfg_data[1:0];
                shmm_pkg::REG_HASH_MASK:   cfg_next.hash_mask       = cfg_data;
                shmm_pkg::REG_INIT_VALUE:  cfg_next.init_value      = cfg_data;
                shmm_pkg::REG_END_CHAR:    cfg_next.end_char        = cfg_data[7:0];
                shmm_pkg::REG_ZERO_FIX_EN: cfg_next.zero_fix_enable = cfg_data[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hash_mode       <= shmm_pkg::MODE_DJB2;
            cfg_reg.hash_mask       <= shmm_pkg::HASH_MASK_RESET;
            cfg_reg.init_value      <= shmm_pkg::INIT_VALUE_RESET;
            cfg_reg.end_char        <= shmm_pkg::END_CHAR_RESET;
            cfg_reg.zero_fix_enable <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/shmm_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shmm_core
// Input register, per-string hash state and result register
// ----------------------------------------------------------------------------
module shmm_core #(
    parameter int MAX_CHARS = shmm_pkg::MAX_CHARS_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire shmm_pkg::cfg_t cfg,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [7:0]     char_byte,
    input  wire logic           last_item,
    input  wire logic           empty_string,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [31:0]         hash_value
);

    localparam int CW = $clog2(MAX_CHARS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CHARS);

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        in_empty_reg;

    // string state
    logic [31:0]   hash_acc_reg, hash_acc_next;
    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic          stopped_reg, stopped_next;
    logic [7:0]    first_byte_reg, first_byte_next;
    logic          mid_string_reg, mid_string_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_hash_reg, out_hash_next;

    logic        produce;
    logic        advance;
    logic        start;
    logic [31:0] h0;
    logic [CW-1:0] cnt0;
    logic        stop0;
    logic [31:0] masked;
    logic [31:0] first_masked;

    assign produce  = in_last_reg | in_empty_reg;
    assign advance  = in_valid_reg & (~produce | ~out_valid_reg | ~out_stall);
    assign in_stall = in_valid_reg & ~advance;
    assign start    = ~mid_string_reg;

    always_comb
    begin
        h0    = start ? cfg.init_value : hash_acc_reg;
        cnt0  = start ? '0 : byte_count_reg;
        stop0 = start ? 1'b0 : stopped_reg;

        hash_acc_next   = hash_acc_reg;
        byte_count_next = byte_count_reg;
        stopped_next    = stopped_reg;
        first_byte_next = first_byte_reg;
        mid_string_next = mid_string_reg;
        out_hash_next   = out_hash_reg;
        masked          = '0;
        first_masked    = '0;

        if (advance)
        begin
            if (in_empty_reg)
            begin
                hash_acc_next   = cfg.init_value;
                byte_count_next = '0;
                stopped_next    = 1'b0;
                mid_string_next = 1'b0;
                out_hash_next   = cfg.zero_fix_enable ? 32'd0
                                                      : (cfg.init_value & cfg.hash_mask);
            end
            else
            begin
                hash_acc_next   = h0;
                byte_count_next = cnt0;
                stopped_next    = stop0;
                first_byte_next = start ? in_byte_reg : first_byte_reg;
                if (!stop0 && (cnt0 < MAX_CNT))
                begin
                    if (in_byte_reg == cfg.end_char)
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        hash_acc_next   = shmm_pkg::fold(cfg.hash_mode, h0, in_byte_reg);
                        byte_count_next = cnt0 + 1'b1;
                    end
                end
                mid_string_next = ~in_last_reg;

                if (in_last_reg)
                begin
                    masked       = hash_acc_next & cfg.hash_mask;
                    first_masked = {24'd0, first_byte_next} & cfg.hash_mask;
                    if (masked == 32'd0 && cfg.zero_fix_enable)
                    begin
                        out_hash_next = (first_masked == 32'd0) ? 32'd1 : first_masked;
                    end
                    else
                    begin
                        out_hash_next = masked;
                    end
                end
            end
        end

        if (advance && produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        in_valid_next = in_stall ? in_valid_reg : in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            hash_acc_reg   <= shmm_pkg::INIT_VALUE_RESET;
            byte_count_reg <= '0;
            stopped_reg    <= 1'b0;
            first_byte_reg <= '0;
            mid_string_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            hash_acc_reg   <= hash_acc_next;
            byte_count_reg <= byte_count_next;
            stopped_reg    <= stopped_next;
            first_byte_reg <= first_byte_next;
            mid_string_reg <= mid_string_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg  <= char_byte;
            in_last_reg  <= last_item;
            in_empty_reg <= empty_string;
        end
        out_hash_reg <= out_hash_next;
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = out_hash_reg;

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> !in_stall)
        else $error("input stalled with no word held");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= MAX_CNT)
        else $error("byte count beyond limit");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance && produce |=> out_valid_reg)
        else $error("final word did not load a result");

    a_string_closed: assert property (@(posedge clk) disable iff (!rst_n)
        advance && produce |=> !mid_string_reg)
        else $error("string still open after final word");

endmodule
`default_nettype wire

FILE: hw/rtl/string_hash_multi_mode_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// string_hash_multi_mode_unit
// djb2 / djb2a / sdbm string hash over a byte stream with masking and fixup
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_stall   | char_byte, last_item, empty_string
//  out     | out_valid / out_stall | hash_value
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  one byte per cycle sustained unless a final word waits on a stalled result; the
//  final word passes through the input register, then the result register
//  the hash accumulator update is a combinational add/shift in the core
//  in_stall rises only when a final or empty-string word waits on a stalled held result
//  reset loads the register defaults and clears all string state
//  cfg_ready is always high
// ----------------------------------------------------------------------------
module string_hash_multi_mode_unit #(
    parameter int MAX_CHARS = shmm_pkg::MAX_CHARS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [7:0]                        char_byte,
    input  wire logic                              last_item,
    input  wire logic                              empty_string,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [31:0]                            hash_value,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [shmm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [31:0]                       cfg_data
);

    shmm_pkg::cfg_t cfg;

    assign cfg_ready = 1'b1;

    shmm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    shmm_core #(
        .MAX_CHARS (MAX_CHARS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_byte    (char_byte),
        .last_item    (last_item),
        .empty_string (empty_string),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hash_value   (hash_value)
    );

endmodule
`default_nettype wire

FILE: bench/string_hash_multi_mode_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// string_hash_multi_mode_unit_tb
// Drives byte strings through the hash unit under a range of register
// settings and checks every hash against a cycle-free software predictor.
// Directed strings hit each mode, end character and zero fixup; random
// strings follow, with lengths around the limit, random input gaps and output
// stalls, and a final stretch at full rate.
// ----------------------------------------------------------------------------
module string_hash_multi_mode_unit_tb;

    localparam int          STR_LIMIT   = shmm_pkg::MAX_CHARS_DEFAULT;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic [7:0]                       char_byte;
    logic                             last_item;
    logic                             empty_string;
    logic                             out_valid;
    logic                             out_stall;
    logic [31:0]                      hash_value;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [shmm_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]                      cfg_data;

    // predictor state
    shmm_pkg::cfg_t         regs_shadow;
    logic [31:0]            run_hash;
    int unsigned            folded_count;
    logic                   halted;
    logic [7:0]             lead_byte;
    logic                   in_string;
    logic [31:0]            hash_expected[$];

    logic                   gaps_on;
    logic                   stalls_on;
    int unsigned            stall_left;
    int unsigned            words_sent;
    int unsigned            words_hashed;
    int unsigned            hashes_checked;
    int unsigned            reg_writes;
    int unsigned            mismatches;

    logic [1:0]             mode_list [4] = '{shmm_pkg::MODE_DJB2, shmm_pkg::MODE_DJB2A,
                                              shmm_pkg::MODE_SDBM, MODE_UNUSED};

    string_hash_multi_mode_unit #(
        .MAX_CHARS(STR_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .char_byte(char_byte),
        .last_item(last_item),
        .empty_string(empty_string),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .hash_value(hash_value),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4ms;
        $display("%0t: timeout, %0d hashes still outstanding", $time, hash_expected.size());
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [31:0] next_hash(input logic [1:0] mode, input logic [31:0] h,
                                              input logic [7:0] b);
        case (mode)
            shmm_pkg::MODE_DJB2:  next_hash = h * 32'd33 + {24'd0, b};
            shmm_pkg::MODE_DJB2A: next_hash = (h * 32'd33) ^ {24'd0, b};
            default:              next_hash = h * 32'd65599 + {24'd0, b};
        endcase
    endfunction

    task automatic predict_word(input logic [7:0] b, input logic last, input logic empty);
        logic [31:0] h;
        if (empty)
        begin
            hash_expected.push_back(regs_shadow.zero_fix_enable ? 32'd0
                                    : regs_shadow.init_value & regs_shadow.hash_mask);
            run_hash     = regs_shadow.init_value;
            folded_count = 0;
            halted       = 1'b0;
            in_string    = 1'b0;
            words_hashed++;
        end
        else
        begin
            if (!in_string)
            begin
                run_hash     = regs_shadow.init_value;
                folded_count = 0;
                halted       = 1'b0;
                lead_byte    = b;
                in_string    = 1'b1;
            end
            if (!halted && folded_count < STR_LIMIT)
            begin
                words_hashed++;
                if (b == regs_shadow.end_char)
                    halted = 1'b1;
                else
                begin
                    run_hash = next_hash(regs_shadow.hash_mode, run_hash, b);
                    folded_count++;
                end
            end
            else if (last)
                words_hashed++;
            if (last)
            begin
                h = run_hash & regs_shadow.hash_mask;
                if (h == 32'd0 && regs_shadow.zero_fix_enable)
                begin
                    h = {24'd0, lead_byte} & regs_shadow.hash_mask;
                    if (h == 32'd0)
                        h = 32'd1;
                end
                hash_expected.push_back(h);
                in_string = 1'b0;
            end
        end
    endtask

    task automatic send_word(input logic [7:0] b, input logic last, input logic empty);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid  <= 1'b0;
            char_byte <= 8'($urandom);
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        char_byte    <= b;
        last_item    <= last;
        empty_string <= empty;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_word(b, last, empty);
        words_sent++;
    endtask

    // lets queued hashes and any word still in the pipe drain out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (hash_expected.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [shmm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            shmm_pkg::REG_HASH_MODE:   regs_shadow.hash_mode       = data[1:0];
            shmm_pkg::REG_HASH_MASK:   regs_shadow.hash_mask       = data;
            shmm_pkg::REG_INIT_VALUE:  regs_shadow.init_value      = data;
            shmm_pkg::REG_END_CHAR:    regs_shadow.end_char        = data[7:0];
            shmm_pkg::REG_ZERO_FIX_EN: regs_shadow.zero_fix_enable = data[0];
            default: ;
        endcase
    endtask

    task automatic pick_config(input int unsigned phase);
        logic [31:0] mask;
        logic [31:0] start;
        logic [7:0]  stop;
        case ($urandom_range(0, 4))
            0: mask = 32'hFFFF_FFFF;
            1: mask = 32'h0;
            2: mask = $urandom;
            3: mask = 32'h0000_000F;
            default: mask = 32'd1 << $urandom_range(0, 31);
        endcase
        case ($urandom_range(0, 3))
            0: start = 32'h0;
            1: start = 32'hFFFF_FFFF;
            2: start = $urandom;
            default: start = shmm_pkg::INIT_VALUE_RESET;
        endcase
        case ($urandom_range(0, 2))
            0: stop = 8'h00;
            1: stop = 8'hFF;
            default: stop = 8'($urandom);
        endcase
        write_reg(shmm_pkg::REG_HASH_MODE, {30'($urandom), mode_list[phase % 4]});
        write_reg(shmm_pkg::REG_HASH_MASK, mask);
        write_reg(shmm_pkg::REG_INIT_VALUE, start);
        write_reg(shmm_pkg::REG_END_CHAR, {24'($urandom), stop});
        write_reg(shmm_pkg::REG_ZERO_FIX_EN, {31'($urandom), 1'($urandom)});
    endtask

    task automatic send_random_string();
        int unsigned len;
        int unsigned pick;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            send_word(8'($urandom), 1'($urandom), 1'b1);
            return;
        end
        len = (pick < 16) ? $urandom_range(STR_LIMIT - 3, STR_LIMIT + 8) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
        begin
            // broken string: abandoned by an empty marker
            if (i > 0 && $urandom_range(0, 99) == 0)
            begin
                send_word(8'($urandom), 1'($urandom), 1'b1);
                return;
            end
            b = 8'($urandom);
            if ($urandom_range(0, 19) == 0)
                b = regs_shadow.end_char;
            send_word(b, i == len - 1, 1'b0);
        end
    endtask

    task automatic test_default_config();
        send_word(8'h62, 1'b0, 1'b0);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic test_modes();
        for (int m = 0; m < 4; m++)
        begin
            write_reg(shmm_pkg::REG_HASH_MODE, {30'h3FFF_FFFF, mode_list[m]});
            send_word(8'hFF, 1'b0, 1'b0);
            send_word(8'h80, 1'b1, 1'b0);
        end
        wait_idle();
    endtask

    task automatic test_stop_and_fixup();
        // zero hash falls back to the first byte, then to one
        write_reg(shmm_pkg::REG_INIT_VALUE, 32'h0);
        write_reg(shmm_pkg::REG_END_CHAR, 32'h41);
        send_word(8'h41, 1'b1, 1'b0);
        write_reg(shmm_pkg::REG_ZERO_FIX_EN, 32'h0);
        send_word(8'h41, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b1);
        write_reg(shmm_pkg::REG_ZERO_FIX_EN, 32'h1);
        write_reg(shmm_pkg::REG_END_CHAR, 32'h0);
        send_word(8'h00, 1'b1, 1'b0);
        write_reg(shmm_pkg::REG_HASH_MASK, 32'h0);
        send_word(8'h78, 1'b1, 1'b0);
        // end character in the middle of a string
        write_reg(shmm_pkg::REG_HASH_MASK, 32'hFFFF_FFFF);
        write_reg(shmm_pkg::REG_INIT_VALUE, shmm_pkg::INIT_VALUE_RESET);
        write_reg(shmm_pkg::REG_END_CHAR, 32'h63);
        send_word(8'h7A, 1'b0, 1'b0);
        send_word(8'h63, 1'b0, 1'b0);
        send_word(8'h61, 1'b1, 1'b0);
        // empty marker abandons the open string
        send_word(8'h31, 1'b0, 1'b0);
        send_word(8'h32, 1'b0, 1'b0);
        send_word(8'h33, 1'b1, 1'b1);
        // index past the register list is dropped
        write_reg(shmm_pkg::REG_ZERO_FIX_EN + 3'($urandom_range(1, 3)), $urandom);
        send_word(8'h55, 1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic test_random_strings();
        int unsigned goal;
        for (int p = 0; p < 12; p++)
        begin
            pick_config(p);
            goal = words_hashed + 95;
            while (words_hashed < goal) send_random_string();
        end
        wait_idle();
    endtask

    task automatic test_line_rate();
        int unsigned goal;
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        pick_config($urandom_range(0, 3));
        goal = words_hashed + 150;
        while (words_hashed < goal) send_random_string();
        wait_idle();
    endtask

    // output stall bursts; a new burst starts only while out_stall is low, so bursts never join
    always @(posedge clk)
    begin
        if (stalls_on && !out_stall && stall_left == 0 && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 13);
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : hash_check
        logic [31:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (hash_expected.size() == 0)
            begin
                $display("%0t: hash_value expected none, actual %h", $time, hash_value);
                mismatches++;
            end
            else
            begin
                want = hash_expected.pop_front();
                hashes_checked++;
                if (hash_value !== want)
                begin
                    $display("%0t: hash_value expected %h, actual %h", $time, want, hash_value);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        char_byte    <= 8'h00;
        last_item    <= 1'b0;
        empty_string <= 1'b0;
        out_stall    <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= shmm_pkg::REG_HASH_MODE;
        cfg_data     <= 32'h0;
        regs_shadow  = '{shmm_pkg::MODE_DJB2, shmm_pkg::HASH_MASK_RESET,
                         shmm_pkg::INIT_VALUE_RESET, shmm_pkg::END_CHAR_RESET, 1'b1};
        run_hash     = shmm_pkg::INIT_VALUE_RESET;
        folded_count = 0;
        halted       = 1'b0;
        lead_byte    = 8'h00;
        in_string    = 1'b0;
        stall_left   = 0;
        words_sent   = 0;
        words_hashed = 0;
        hashes_checked = 0;
        reg_writes   = 0;
        mismatches   = 0;
        gaps_on      = 1'b1;
        stalls_on    = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_config();
        test_modes();
        test_stop_and_fixup();
        test_random_strings();
        test_line_rate();

        repeat (8) @(posedge clk);
        $display("sent %0d words over all hash modes, masks and stop settings", words_sent);
        $display("checked %0d hashes after %0d register writes", hashes_checked, reg_writes);
        if (mismatches == 0 && hash_expected.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
